[design/icp_pkg.sv]
// shared types and constants for the infix to postfix converter
// operator and result codes, controller command and status structs
// no dependencies
package icp_pkg;

	// operator codes, same on input and output
	localparam logic [2:0] OP_LPAREN = 3'd0;
	localparam logic [2:0] OP_RPAREN = 3'd1;
	localparam logic [2:0] OP_POW    = 3'd2;
	localparam logic [2:0] OP_MUL    = 3'd3;
	localparam logic [2:0] OP_DIV    = 3'd4;
	localparam logic [2:0] OP_ADD    = 3'd5;
	localparam logic [2:0] OP_SUB    = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_OPERAND  = 2'd0;
	localparam logic [1:0] KIND_OPERATOR = 2'd1;
	localparam logic [1:0] KIND_MARKER   = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_UNMATCHED = 2'd2;

	// results kept per item, further ones are dropped
	localparam int MAX_RESULTS = 17;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	localparam int VALUE_W = 32;
	localparam int OP_W    = 3;
	localparam int KIND_W  = 2;
	localparam int ERR_W   = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	typedef struct packed {
		logic             load;
		logic             push;
		logic             pop;
		logic             emit;
		logic [KIND_W-1:0] emit_kind;
		logic [ERR_W-1:0] emit_err;
		logic             finish;
	} icp_cmd_t;

	typedef struct packed {
		logic             is_operand;
		logic [OP_W-1:0]  op;
		logic             last;
		logic [OP_W-1:0]  top_op;
		logic             empty;
		logic             full;
		logic             emit_ok;
		logic             finish_ok;
		logic             res_none;
	} icp_sts_t;

endpackage

[design/infix_to_postfix_converter.sv]
// top level of the infix to postfix converter (shunting-yard)
// joins the controller and the datapath
// depends on icp_pkg, icp_ctrl, icp_dpath
//
// Input channel s_*: one infix token per item. s_tuser is 1 for an operand,
// s_tlast marks the final token of an expression and flushes the stack.
// Output channel m_*: postfix results. m_tuser gives the kind (operand,
// operator, empty marker), m_tlast marks the final result of an expression.
// One item at a time: an item is accepted, decoded and then closed out;
// * / + - and ) first pop operators one by one, then push, drop the matching
// ( or send the error marker; the final token then pops each stack entry.
// The operator stack is a memory of STACK_DEPTH entries with a registered
// top read; its contents need no clearing, reset empties the count, the
// controller and the valid and token flags. When the receiver stalls, results
// wait in the output register and one pending register, and the stack
// sequencer halts until room is made; no result is lost to a stall, but
// results past MAX_RESULTS per item are dropped.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // operand_value[31:0], operator_code[34:32], zero pad
	input  logic        s_tuser,  // token_is_operand
	input  logic        s_tlast,  // last_token
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // out_value[31:0], out_operator[34:32], error_code[36:35]
	output logic [1:0]  m_tuser,  // out_kind
	output logic        m_tlast   // end_of_expression
);
	import icp_pkg::*;

	icp_cmd_t cmd;
	icp_sts_t sts;

	icp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	icp_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

[design/icp_ctrl.sv]
// controller state machine of the infix to postfix converter
// sequences pushes, pops and result emission for one item at a time
// depends on icp_pkg
module icp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  icp_pkg::icp_sts_t sts,
	output icp_pkg::icp_cmd_t cmd
);
	import icp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_POP    = 6'b000100,
		ST_CLOSE  = 6'b001000,
		ST_FLUSH  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d, after;
	logic   pop_hit;
	logic   tight_op;
	logic   top_tight;

	assign after     = sts.last ? ST_FLUSH : ST_DONE;
	assign tight_op  = (sts.op == OP_MUL) || (sts.op == OP_DIV);
	assign top_tight = (sts.top_op == OP_POW) || (sts.top_op == OP_MUL) ||
		(sts.top_op == OP_DIV);
	// * and / pop only tighter or equal operators, + and - pop down to (
	assign pop_hit = !sts.empty && (tight_op ? top_tight : (sts.top_op != OP_LPAREN));

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_operand) begin
					if (sts.emit_ok) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_OPERAND;
						state_d       = after;
					end
				end else begin
					case (sts.op)
						OP_LPAREN, OP_POW: begin
							if (!sts.full) begin
								cmd.push = 1'b1;
								state_d  = after;
							end else if (sts.emit_ok) begin
								cmd.emit      = 1'b1;
								cmd.emit_kind = KIND_MARKER;
								cmd.emit_err  = ERR_OVERFLOW;
								state_d       = after;
							end
						end
						OP_MUL, OP_DIV, OP_ADD, OP_SUB: state_d = ST_POP;
						OP_RPAREN: state_d = ST_CLOSE;
						default: state_d = after;
					endcase
				end
			end
			ST_POP: begin
				if (pop_hit) begin
					if (sts.emit_ok) begin
						cmd.pop       = 1'b1;
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_OPERATOR;
					end
				end else if (!sts.full) begin
					cmd.push = 1'b1;
					state_d  = after;
				end else if (sts.emit_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_MARKER;
					cmd.emit_err  = ERR_OVERFLOW;
					state_d       = after;
				end
			end
			ST_CLOSE: begin
				if (sts.empty) begin
					if (sts.emit_ok) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_MARKER;
						cmd.emit_err  = ERR_UNMATCHED;
						state_d       = after;
					end
				end else if (sts.top_op == OP_LPAREN) begin
					cmd.pop = 1'b1;
					state_d = after;
				end else if (sts.emit_ok) begin
					cmd.pop       = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_OPERATOR;
				end
			end
			ST_FLUSH: begin
				if (!sts.empty) begin
					// a leftover ( is dropped silently
					if (sts.top_op == OP_LPAREN) begin
						cmd.pop = 1'b1;
					end else if (sts.emit_ok) begin
						cmd.pop       = 1'b1;
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_OPERATOR;
					end
				end else if (sts.res_none) begin
					// nothing came out, send an empty marker to carry the end flag
					if (sts.emit_ok) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_MARKER;
						cmd.emit_err  = ERR_NONE;
						state_d       = ST_DONE;
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.finish_ok) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/icp_dpath.sv]
// datapath of the infix to postfix converter
// token latch, operator stack memory with top read, pending and output registers
// depends on icp_pkg
module icp_dpath #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [icp_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [icp_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [icp_pkg::KIND_W-1:0]      m_tuser,
	output logic                            m_tlast,
	input  icp_pkg::icp_cmd_t               cmd,
	output icp_pkg::icp_sts_t               sts
);
	import icp_pkg::*;

	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// latched token
	logic               is_operand_q;
	logic [VALUE_W-1:0] value_q;
	logic [OP_W-1:0]    op_q;
	logic               last_q;

	// operator stack
	logic [OP_W-1:0] stack_mem [STACK_DEPTH];
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic [CW-1:0]   top_idx;
	logic [OP_W-1:0] top_q;

	// pending result, held back so the end flag can land on the final one
	logic               pend_v_q;
	logic [KIND_W-1:0]  pend_kind_q;
	logic [VALUE_W-1:0] pend_value_q;
	logic [OP_W-1:0]    pend_op_q;
	logic [ERR_W-1:0]   pend_err_q;

	// output register
	logic               out_v_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [OP_W-1:0]    out_op_q;
	logic [ERR_W-1:0]   out_err_q;
	logic               out_end_q;

	logic [RES_W-1:0]   res_cnt_q;
	logic               res_full;
	logic               out_free;
	logic               do_emit;
	logic               move_out;

	assign res_full = (res_cnt_q == RES_W'(MAX_RESULTS));
	assign out_free = !out_v_q || m_tready;
	assign do_emit  = cmd.emit && !res_full;
	assign move_out = (do_emit && pend_v_q) || (cmd.finish && pend_v_q);

	assign count_d = cmd.push ? count_q + CW'(1) : (cmd.pop ? count_q - CW'(1) : count_q);
	assign top_idx = count_d - CW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= s_tdata[VALUE_W-1:0];
			op_q    <= s_tdata[VALUE_W +: OP_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_operand_q <= 1'b0;
			last_q       <= 1'b0;
		end else if (cmd.load) begin
			is_operand_q <= s_tuser;
			last_q       <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[count_q[IW-1:0]] <= op_q;
		end
	end

	// top entry read every cycle at the next count, bypassed on a push
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= op_q;
		end else begin
			top_q <= stack_mem[top_idx[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.finish) begin
				res_cnt_q <= '0;
				pend_v_q  <= 1'b0;
			end else if (do_emit) begin
				res_cnt_q <= res_cnt_q + RES_W'(1);
				pend_v_q  <= 1'b1;
			end
			if (move_out) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			pend_kind_q  <= cmd.emit_kind;
			pend_value_q <= (cmd.emit_kind == KIND_OPERAND) ? value_q : '0;
			pend_op_q    <= (cmd.emit_kind == KIND_OPERATOR) ? top_q : '0;
			pend_err_q   <= cmd.emit_err;
		end
		if (move_out) begin
			out_kind_q  <= pend_kind_q;
			out_value_q <= pend_value_q;
			out_op_q    <= pend_op_q;
			out_err_q   <= pend_err_q;
			out_end_q   <= cmd.finish && last_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_end_q;
	assign m_tdata  = {{(OUT_DATA_W - VALUE_W - OP_W - ERR_W){1'b0}},
		out_err_q, out_op_q, out_value_q};

	always_comb begin
		sts            = '0;
		sts.is_operand = is_operand_q;
		sts.op         = op_q;
		sts.last       = last_q;
		sts.top_op     = top_q;
		sts.empty      = (count_q == '0);
		sts.full       = (count_q == CW'(STACK_DEPTH));
		sts.emit_ok    = res_full || !pend_v_q || out_free;
		sts.finish_ok  = !pend_v_q || out_free;
		sts.res_none   = (res_cnt_q == '0);
	end

endmodule
